// ----- rtl/core/rpg_pkg.sv -----
// rpg_pkg: shared types and constants of the random permutation generator.
// Depends on nothing; imported by rpg_ctrl, rpg_dp and the top level.
package rpg_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = 11;
    localparam int CNT_W    = IDX_W + 1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_GEN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_seed;   // take seed into generator
        logic fill_start;  // clear fill counter, set position to length-1
        logic fill_step;   // write identity entry, advance counter
        logic draw;        // step generator, start modulo
        logic mod_step;    // one restoring-division step
        logic rd_a;        // read entry at position
        logic rd_b;        // read entry at j
        logic wr_a;        // write b-data at position
        logic wr_b;        // write a-data at j
        logic pos_dec;     // move to next lower position
        logic rd_user;     // read entry at user index
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_done;
        logic mod_done;
        logic pos_last;
        logic len_zero;
    } t_stat;

endpackage

// ----- rtl/core/random_permutation_generator.sv -----
// Random permutation generator: top level with output register.
// Depends on rpg_pkg, rpg_ctrl and rpg_dp.
//
// One item is worked at a time. Generate runs for length L: an identity
// fill through the single memory port, then per position one generator
// step, a bit-serial modulo and two reads and two writes on the memory
// port for the swap. The result sits in an output register; a new item
// is taken only while that register is free or i_ready empties it.
module random_permutation_generator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_opcode,
    input  logic [63:0]               i_seed_lo,
    input  logic [63:0]               i_seed_hi,
    input  logic [9:0]                i_index,
    input  logic                      i_cfg_we,
    input  logic [10:0]               i_cfg_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [9:0]                o_entry_value,
    output logic [1:0]                o_status,
    output logic [63:0]               o_state_lo,
    output logic [63:0]               o_state_hi
);
    import rpg_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready, w_done, w_rd_ok;
    logic  w_accept;
    logic [1:0] w_status;
    logic [IDX_W-1:0] w_rd;
    logic [63:0] w_slo, w_shi;
    logic [LEN_W-1:0] r_len;
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_len <= LEN_W'(MAX_LEN);
        else if (i_cfg_we)
            r_len <= i_cfg_data;
    end

    // start the controller only on a real input transfer
    assign w_accept = i_valid && o_ready;

    rpg_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid(w_accept), .o_ready(w_ready), .i_opcode, .i_index,
        .i_len(r_len), .i_stat(w_stat), .o_cmd(w_cmd), .o_done(w_done),
        .o_rd_ok(w_rd_ok), .o_status(w_status)
    );

    rpg_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat), .i_len(r_len),
        .i_seed_lo, .i_seed_hi, .i_index, .o_rd_data(w_rd),
        .o_state_lo(w_slo), .o_state_hi(w_shi)
    );

    // hold the controller while an earlier result still waits
    assign o_ready = w_ready && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ovalid <= 1'b0;
        else if (w_done)
            r_ovalid <= 1'b1;
        else if (i_ready)
            r_ovalid <= 1'b0;
        if (w_done) begin
            o_entry_value <= w_rd_ok ? w_rd : '0;
            o_status      <= w_status;
            o_state_lo    <= w_slo;
            o_state_hi    <= w_shi;
        end
    end

    assign o_valid = r_ovalid;

    // done only lands when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (!$past(r_ovalid) || $past(i_ready)))
        else $error("result overwritten");
    a_rd_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_rd_ok) |-> (w_status == ST_OK))
        else $error("read data with error status");

endmodule

// ----- rtl/core/rpg_dp.sv -----
// rpg_dp: generator state, permutation memory, serial modulo unit.
// Depends on rpg_pkg; driven by rpg_ctrl commands.
module rpg_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rpg_pkg::t_cmd              i_cmd,
    output rpg_pkg::t_stat             o_stat,
    input  logic [rpg_pkg::LEN_W-1:0]  i_len,
    input  logic [63:0]                i_seed_lo,
    input  logic [63:0]                i_seed_hi,
    input  logic [rpg_pkg::IDX_W-1:0]  i_index,
    output logic [rpg_pkg::IDX_W-1:0]  o_rd_data,
    output logic [63:0]                o_state_lo,
    output logic [63:0]                o_state_hi
);
    import rpg_pkg::*;

    logic [31:0] r_w0, r_w1, r_w2, r_w3;
    logic [31:0] n_w0, n_w1, n_w2, n_w3;
    logic [31:0] w_mul5, w_rot, w_out;
    logic [IDX_W-1:0] r_mem [MAX_LEN];
    logic [IDX_W-1:0] r_rd;
    logic [IDX_W-1:0] r_a;
    logic [CNT_W-1:0] r_fill, r_pos;
    logic [31:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [5:0] r_bit;
    logic [CNT_W:0] w_trial;
    logic [CNT_W-1:0] w_div;
    logic [CNT_W-1:0] w_leff;

    assign w_leff = (i_len > LEN_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : CNT_W'(i_len);
    assign w_div  = r_pos + CNT_W'(1);

    assign w_mul5 = r_w1 * 32'd5;
    assign w_rot  = {w_mul5[24:0], w_mul5[31:25]};
    assign w_out  = w_rot * 32'd9;

    always_comb begin
        n_w2 = r_w2 ^ r_w0;
        n_w3 = r_w3 ^ r_w1;
        n_w1 = r_w1 ^ n_w2;
        n_w0 = r_w0 ^ n_w3;
        n_w2 = n_w2 ^ (r_w1 << 9);
        n_w3 = {n_w3[20:0], n_w3[31:21]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= '0; r_w1 <= '0; r_w2 <= '0; r_w3 <= '0;
        end else if (i_cmd.load_seed) begin
            r_w0 <= i_seed_lo[31:0];  r_w1 <= i_seed_lo[63:32];
            r_w2 <= i_seed_hi[31:0];  r_w3 <= i_seed_hi[63:32];
        end else if (i_cmd.draw) begin
            r_w0 <= n_w0; r_w1 <= n_w1; r_w2 <= n_w2; r_w3 <= n_w3;
        end
    end

    // serial modulo: one quotient bit per cycle, over all 32 quotient bits
    assign w_trial = {r_rem, r_quo[31]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.draw) begin
            r_quo <= w_out;
            r_rem <= '0;
            r_bit <= '0;
        end else if (i_cmd.mod_step) begin
            r_quo <= {r_quo[30:0], 1'b0};
            r_bit <= r_bit + 6'd1;
            if (w_trial >= {1'b0, w_div})
                r_rem <= CNT_W'(w_trial - {1'b0, w_div});
            else
                r_rem <= w_trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_start) begin
            r_fill <= '0;
            r_pos  <= w_leff - CNT_W'(1);
        end else begin
            if (i_cmd.fill_step)
                r_fill <= r_fill + CNT_W'(1);
            if (i_cmd.pos_dec)
                r_pos <= r_pos - CNT_W'(1);
        end
    end

    // single-port memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_step)
            r_mem[r_fill[IDX_W-1:0]] <= r_fill[IDX_W-1:0];
        else if (i_cmd.wr_a)
            r_mem[r_pos[IDX_W-1:0]] <= r_rd;
        else if (i_cmd.wr_b)
            r_mem[r_rem[IDX_W-1:0]] <= r_a;
        if (i_cmd.rd_a)
            r_rd <= r_mem[r_pos[IDX_W-1:0]];
        else if (i_cmd.rd_b)
            r_rd <= r_mem[r_rem[IDX_W-1:0]];
        else if (i_cmd.rd_user)
            r_rd <= r_mem[i_index];
        if (i_cmd.rd_b)
            r_a <= r_rd;
    end

    assign o_stat.fill_done = (r_fill + CNT_W'(1) >= w_leff);
    assign o_stat.mod_done  = (r_bit == 6'd31);
    assign o_stat.pos_last  = (r_pos == '0);
    assign o_stat.len_zero  = (i_len == '0);
    assign o_rd_data  = r_rd;
    assign o_state_lo = {r_w1, r_w0};
    assign o_state_hi = {r_w3, r_w2};

endmodule

// ----- rtl/core/rpg_ctrl.sv -----
// rpg_ctrl: sequencer for load, generate and read operations.
// Depends on rpg_pkg; commands rpg_dp.
module rpg_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_opcode,
    input  logic [rpg_pkg::IDX_W-1:0] i_index,
    input  logic [rpg_pkg::LEN_W-1:0] i_len,
    input  rpg_pkg::t_stat            i_stat,
    output rpg_pkg::t_cmd             o_cmd,
    output logic                      o_done,
    output logic                      o_rd_ok,
    output logic [1:0]                o_status
);
    import rpg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_DRAW, S_MOD, S_RDA, S_RDB, S_WRA, S_WRB, S_RDU, S_DONE
    } t_state;

    t_state r_state;
    logic r_valid, r_rd_ok;
    logic [1:0] r_status;
    logic [LEN_W-1:0] w_leff;

    assign w_leff = (i_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : i_len;
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_rd_ok <= 1'b0;
            r_status <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_rd_ok  <= 1'b0;
                    r_status <= ST_OK;
                    priority if (i_opcode == OP_GEN) begin
                        r_valid <= 1'b1;
                        r_state <= i_stat.len_zero ? S_DONE : S_FILL;
                    end else if (i_opcode == OP_READ) begin
                        if (!r_valid) begin
                            r_status <= ST_NONE;
                            r_state  <= S_DONE;
                        end else if ({1'b0, i_index} >= w_leff) begin
                            r_status <= ST_RANGE;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_RDU;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FILL: if (i_stat.fill_done) r_state <= S_DRAW;
                S_DRAW: r_state <= S_MOD;
                S_MOD:  if (i_stat.mod_done) r_state <= S_RDA;
                S_RDA:  r_state <= S_RDB;
                S_RDB:  r_state <= S_WRA;
                S_WRA:  r_state <= S_WRB;
                S_WRB:  r_state <= i_stat.pos_last ? S_DONE : S_DRAW;
                S_RDU: begin
                    r_rd_ok <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load_seed  = (r_state == S_IDLE) && i_valid && (i_opcode == OP_LOAD);
        o_cmd.fill_start = (r_state == S_IDLE);
        o_cmd.fill_step  = (r_state == S_FILL);
        o_cmd.draw       = (r_state == S_DRAW);
        o_cmd.mod_step   = (r_state == S_MOD);
        o_cmd.rd_a       = (r_state == S_RDA);
        o_cmd.rd_b       = (r_state == S_RDB);
        o_cmd.wr_a       = (r_state == S_WRA);
        o_cmd.wr_b       = (r_state == S_WRB);
        o_cmd.pos_dec    = (r_state == S_WRB);
        o_cmd.rd_user    = (r_state == S_IDLE) && i_valid;
    end

    assign o_done   = (r_state == S_DONE);
    assign o_rd_ok  = r_rd_ok;
    assign o_status = r_status;

endmodule
